/* rtl/sle_pkg.sv */
// Shared types and constants for the sequential list engine.
// Holds the command/status codes, the beat structs and the cell-to-cell link record.
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

   localparam int POS_W = 9;
   localparam int VAL_W = 8;
   localparam int LEN_W = 9;

   typedef enum logic [2:0] {
      CMD_GET    = 3'd0,
      CMD_SET    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_LOCATE = 3'd4,
      CMD_PRED   = 3'd5,
      CMD_SUCC   = 3'd6,
      CMD_CLEAR  = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_BADPOS   = 3'd1,
      ST_FULL     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_NONEIGH  = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type          cmd;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [VAL_W-1:0] out_value;
      logic [POS_W-1:0] out_position;
      logic [LEN_W-1:0] length;
      logic             empty_res;
   } rsp_type;

   // Record that walks the cell chain, one cell per cycle while the chain is not held.
   typedef struct packed {
      logic             live;
      cmd_type          cmd;
      logic [POS_W-1:0] pos;
      logic [VAL_W-1:0] val;       // search key, set value, or insert carry
      logic             ok;        // position checks passed, list may change
      logic             found;     // first match already seen
      logic             need_next; // successor wanted from the next cell
      logic [VAL_W-1:0] prev;      // element of the cell just passed
      logic [VAL_W-1:0] rval;
      logic [POS_W-1:0] opos;
      status_type       status;
   } link_type;

endpackage

`default_nettype wire

/* rtl/sle_cell.sv */
// One list cell: holds a single element and updates it as the command record passes.
// Depends on sle_pkg for the link record and command codes.
`timescale 1ns / 1ps
`default_nettype none

module sle_cell
   import sle_pkg::*;
#(
   parameter int IDX   = 0,
   parameter int CNT_W = 9
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic [CNT_W-1:0] cnt,
   input  wire link_type         lnk_i,
   input  wire logic [VAL_W-1:0] right_elem,
   output link_type              lnk_o,
   output logic      [VAL_W-1:0] elem_o
);

   localparam int CW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CW-1:0] MY_POS = CW'(IDX + 1);

   link_type         lnk_ff, lnk_in;
   logic [VAL_W-1:0] elem_ff, elem_in;
   logic [CW-1:0]    pos_x;
   logic             at_pos, from_pos, in_list;

   assign pos_x    = CW'(lnk_i.pos);
   assign at_pos   = (pos_x == MY_POS);
   assign from_pos = (MY_POS >= pos_x);
   assign in_list  = (MY_POS <= CW'(cnt));

   always_comb begin
      lnk_in  = lnk_i;
      elem_in = elem_ff;
      if (lnk_i.live) begin
         unique case (lnk_i.cmd) inside
            CMD_GET: begin
               if (lnk_i.ok && at_pos) lnk_in.rval = elem_ff;
            end
            CMD_SET: begin
               if (lnk_i.ok && at_pos) begin
                  lnk_in.rval = elem_ff;
                  elem_in     = lnk_i.val;
               end
            end
            CMD_INSERT: begin
               // swap with the carry: take the value from the left, pass ours on
               if (lnk_i.ok && from_pos) begin
                  elem_in    = lnk_i.val;
                  lnk_in.val = elem_ff;
               end
            end
            CMD_DELETE: begin
               // right neighbor has not seen the record yet, so pull it down
               if (lnk_i.ok && from_pos) begin
                  if (at_pos) lnk_in.rval = elem_ff;
                  elem_in = right_elem;
               end
            end
            CMD_LOCATE, CMD_PRED, CMD_SUCC: begin
               if (in_list) begin
                  if (lnk_i.need_next) begin
                     lnk_in.rval      = elem_ff;
                     lnk_in.need_next = 1'b0;
                  end
                  if (!lnk_i.found && (elem_ff == lnk_i.val)) begin
                     lnk_in.found = 1'b1;
                     if (lnk_i.cmd == CMD_LOCATE) begin
                        lnk_in.opos = POS_W'(MY_POS);
                     end else if (lnk_i.cmd == CMD_PRED) begin
                        if (IDX == 0) lnk_in.status = ST_NONEIGH;
                        else          lnk_in.rval   = lnk_i.prev;
                     end else begin
                        lnk_in.need_next = 1'b1;
                     end
                  end
               end
               lnk_in.prev = elem_ff;
            end
            CMD_CLEAR: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lnk_ff.live <= 1'b0;
      end else if (adv) begin
         lnk_ff <= lnk_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         elem_ff <= elem_in;
      end
   end

   assign lnk_o  = lnk_ff;
   assign elem_o = elem_ff;

endmodule

`default_nettype wire

/* rtl/sequential_list_engine_top.sv */
// Top level of the sequential list engine: command intake, cell chain, result register.
// Depends on sle_pkg and sle_cell.
//
//   channel | ports                            | direction | beat
//   --------+----------------------------------+-----------+----------------------
//   request | req_valid, req_stall, req_data   | in        | cmd, position, value
//   result  | rsp_valid, rsp_stall, rsp_data   | out       | status, value, pos, length
//
// Each command walks the chain of CAPACITY cells, one cell per cycle while the chain is not
// held: the head register, then each cell register, then the result register. The next
// request beat is taken once the result is registered, so one command is in flight.
// Reset clears the element count and all handshake state; the element cells are not
// cleared. A stalled result holds the chain once the next command reaches the last cell.
`timescale 1ns / 1ps
`default_nettype none

module sequential_list_engine_top
   import sle_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CW    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CAPACITY);

   link_type         head_ff, head_in;
   link_type         lnk [CAPACITY];
   logic [VAL_W-1:0] elem [CAPACITY];
   link_type         tail;
   logic             busy_ff, rsp_valid_ff;
   rsp_type          rsp_data_ff, rsp_next;
   logic [CNT_W-1:0] count_ff, count_next;
   logic             adv, req_acc, tail_done;
   logic [CW-1:0]    pos_x, cnt_x;
   status_type       chk_status;

   assign tail      = lnk[CAPACITY-1];
   // hold the whole chain when the finished beat cannot leave
   assign adv       = !(tail.live && rsp_valid_ff && rsp_stall);
   assign tail_done = tail.live && adv;
   assign req_stall = busy_ff;
   assign req_acc   = req_valid && !busy_ff;

   assign pos_x = CW'(req_data.position);
   assign cnt_x = CW'(count_ff);

   always_comb begin
      chk_status = ST_OK;
      unique case (req_data.cmd) inside
         CMD_GET, CMD_SET, CMD_DELETE: begin
            if (pos_x == '0 || pos_x > cnt_x) chk_status = ST_BADPOS;
         end
         CMD_INSERT: begin
            if (pos_x == '0 || pos_x > cnt_x + CW'(1)) chk_status = ST_BADPOS;
            else if (count_ff == CNT_MAX)              chk_status = ST_FULL;
         end
         CMD_LOCATE, CMD_PRED, CMD_SUCC, CMD_CLEAR: begin
         end
      endcase
   end

   always_comb begin
      head_in = head_ff;
      if (adv) head_in.live = 1'b0;
      if (req_acc) begin
         head_in.live      = 1'b1;
         head_in.cmd       = req_data.cmd;
         head_in.pos       = req_data.position;
         head_in.val       = req_data.value;
         head_in.ok        = (chk_status == ST_OK);
         head_in.found     = 1'b0;
         head_in.need_next = 1'b0;
         head_in.prev      = '0;
         head_in.rval      = '0;
         head_in.opos      = '0;
         head_in.status    = chk_status;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sle_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .cnt        (count_ff),
         .lnk_i      ((i == 0) ? head_ff : lnk[(i == 0) ? 0 : i - 1]),
         .right_elem (elem[(i == CAPACITY - 1) ? i : i + 1]),
         .lnk_o      (lnk[i]),
         .elem_o     (elem[i])
      );
   end

   // finish the search commands and work out the new length
   always_comb begin
      count_next = count_ff;
      unique case (tail.cmd) inside
         CMD_INSERT: if (tail.ok) count_next = count_ff + CNT_W'(1);
         CMD_DELETE: if (tail.ok) count_next = count_ff - CNT_W'(1);
         CMD_CLEAR:  count_next = '0;
         CMD_GET, CMD_SET, CMD_LOCATE, CMD_PRED, CMD_SUCC: begin
         end
      endcase

      rsp_next.status       = tail.status;
      rsp_next.out_value    = tail.rval;
      rsp_next.out_position = tail.opos;
      if (tail.cmd == CMD_LOCATE || tail.cmd == CMD_PRED || tail.cmd == CMD_SUCC) begin
         if (!tail.found) begin
            rsp_next.status    = ST_NOTFOUND;
            rsp_next.out_value = '0;
         end else if (tail.cmd == CMD_SUCC && tail.need_next) begin
            rsp_next.status = ST_NONEIGH;
         end
      end
      rsp_next.length    = LEN_W'(count_next);
      rsp_next.empty_res = (count_next == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.live <= 1'b0;
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         if (req_acc) begin
            busy_ff <= 1'b1;
         end else if (tail_done) begin
            busy_ff <= 1'b0;
         end
         if (tail_done) begin
            count_ff     <= count_next;
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_next;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
